>>> hw/rtl/nca_pkg.sv
// ============================================================================
// nca_pkg
// Shared types and constants for the nearest-centroid assignment block.
// ============================================================================
package nca_pkg;

    localparam int MAX_CENTERS = 16;
    localparam int MAX_DIM     = 128;
    localparam int VALUE_BITS  = 16;
    localparam int CENTER_BITS = 4;
    localparam int DIM_BITS    = 7;
    localparam int NUM_BITS    = 5;
    localparam int ADDR_BITS   = CENTER_BITS + DIM_BITS;
    localparam int DIST_BITS   = 39;
    localparam int COUNT_BITS  = 16;
    localparam int DIFF_BITS   = VALUE_BITS + 1;
    localparam int SQ_BITS     = 2 * DIFF_BITS;

    localparam logic [DIST_BITS-1:0]  DIST_SAT  = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_SAT = '1;
    localparam logic [NUM_BITS-1:0]   NUM_MAX   = NUM_BITS'(MAX_CENTERS);

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_POINT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_SCAN,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic                   load_elem;
        logic                   load_point;
        logic                   rd_en;
        logic [CENTER_BITS-1:0] idx;
        logic                   scan_en;
        logic                   scan_first;
        logic                   emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

>>> hw/rtl/nca_ram.sv
// ============================================================================
// nca_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module nca_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/nca_ctrl.sv
// ============================================================================
// nca_ctrl
// Sequencer: holds the centroid count register, steps the centroid index
// through the distance sweep and the minimum scan, and issues the result.
// ============================================================================
module nca_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [nca_pkg::NUM_BITS-1:0]  cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_req_type,
    input  logic                          s_last,
    input  nca_pkg::dp_status_t           status,
    output nca_pkg::ctrl_cmd_t            cmd
);
    import nca_pkg::*;

    state_t                 state_reg, state_next;
    logic [CENTER_BITS-1:0] idx_reg, idx_next;
    logic                   drain_reg, drain_next;
    logic                   last_reg, last_next;
    logic [NUM_BITS-1:0]    cfg_reg;
    logic [NUM_BITS-1:0]    n_active;
    logic                   idx_at_end;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= NUM_MAX;
        end else if (cfg_wr_en) begin
            cfg_reg <= cfg_wr_data;
        end
    end

    // Zero counts as one centroid; anything past the table saturates.
    always_comb begin
        if (cfg_reg == '0) begin
            n_active = NUM_BITS'(1);
        end else if (cfg_reg > NUM_MAX) begin
            n_active = NUM_MAX;
        end else begin
            n_active = cfg_reg;
        end
    end

    assign idx_at_end = ({1'b0, idx_reg} == (n_active - NUM_BITS'(1)));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            drain_reg <= 1'b0;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            drain_reg <= drain_next;
            last_reg  <= last_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        drain_next = drain_reg;
        last_next  = last_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        cmd.idx    = idx_reg;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_req_type == REQ_POINT) begin
                        cmd.load_point = 1'b1;
                        last_next      = s_last;
                        idx_next       = '0;
                        state_next     = ST_SWEEP;
                    end else begin
                        cmd.load_elem = 1'b1;
                    end
                end
            end
            ST_SWEEP: begin
                cmd.rd_en = 1'b1;
                if (idx_at_end) begin
                    drain_next = 1'b0;
                    state_next = ST_DRAIN;
                end else begin
                    idx_next = idx_reg + CENTER_BITS'(1);
                end
            end
            ST_DRAIN: begin
                drain_next = 1'b1;
                if (drain_reg) begin
                    idx_next   = '0;
                    state_next = last_reg ? ST_SCAN : ST_IDLE;
                end
            end
            ST_SCAN: begin
                cmd.scan_en    = 1'b1;
                cmd.scan_first = (idx_reg == '0);
                if (idx_at_end) begin
                    state_next = ST_RESULT;
                end else begin
                    idx_next = idx_reg + CENTER_BITS'(1);
                end
            end
            ST_RESULT: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_point_starts_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_req_type == REQ_POINT)
        |=> (state_reg == ST_SWEEP) && (idx_reg == '0))
        else $error("point transaction did not start a sweep at centroid zero");

    a_scan_from_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) && ($past(state_reg) != ST_SCAN)
        |-> ($past(state_reg) == ST_DRAIN) && (idx_reg == '0))
        else $error("minimum scan entered without a drained pipeline");

    a_emit_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> (state_reg == ST_IDLE))
        else $error("sequencer did not return to idle after a result");
`endif

endmodule

>>> hw/rtl/nca_datapath.sv
// ============================================================================
// nca_datapath
// Centroid store, squared-difference pipeline, distance accumulators,
// minimum search, member counters and the result register.
// ============================================================================
module nca_datapath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [nca_pkg::CENTER_BITS-1:0] s_center_index,
    input  logic [nca_pkg::DIM_BITS-1:0]   s_dim_index,
    input  logic signed [nca_pkg::VALUE_BITS-1:0] s_value,
    input  nca_pkg::ctrl_cmd_t             cmd,
    output nca_pkg::dp_status_t            status,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [nca_pkg::CENTER_BITS-1:0] m_cluster_id,
    output logic [nca_pkg::DIST_BITS-1:0]  m_distance_sq,
    output logic [nca_pkg::COUNT_BITS-1:0] m_member_count
);
    import nca_pkg::*;

    logic [VALUE_BITS-1:0]  value_reg;
    logic [DIM_BITS-1:0]    dim_reg;
    logic [VALUE_BITS-1:0]  ram_rdata;

    logic                   v1_reg;
    logic [CENTER_BITS-1:0] idx1_reg;
    logic                   v2_reg;
    logic [CENTER_BITS-1:0] idx2_reg;
    logic [SQ_BITS-1:0]     sq2_reg;

    logic [DIFF_BITS-1:0]   diff;
    logic [DIFF_BITS-1:0]   abs_diff;
    logic [SQ_BITS-1:0]     sq;

    logic [DIST_BITS-1:0]   acc_reg [MAX_CENTERS];
    logic [CENTER_BITS-1:0] acc_rd_idx;
    logic [DIST_BITS-1:0]   acc_rd;
    logic [DIST_BITS:0]     acc_sum;
    logic [DIST_BITS-1:0]   acc_new;

    logic [CENTER_BITS-1:0] best_id_reg;
    logic [DIST_BITS-1:0]   best_d_reg;

    logic [COUNT_BITS-1:0]  count_reg [MAX_CENTERS];
    logic [COUNT_BITS-1:0]  count_new;

    logic                   m_valid_reg;
    logic [CENTER_BITS-1:0] m_id_reg;
    logic [DIST_BITS-1:0]   m_dist_reg;
    logic [COUNT_BITS-1:0]  m_count_reg;

    nca_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_CENTERS * MAX_DIM)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (cmd.load_elem),
        .wr_addr ({s_center_index, s_dim_index}),
        .wr_data (s_value),
        .rd_en   (cmd.rd_en),
        .rd_addr ({cmd.idx, dim_reg}),
        .rd_data (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load_point) begin
            value_reg <= s_value;
            dim_reg   <= s_dim_index;
        end
    end

    // Squared difference of the point element and the centroid element.
    assign diff     = {value_reg[VALUE_BITS-1], value_reg}
                    - {ram_rdata[VALUE_BITS-1], ram_rdata};
    assign abs_diff = diff[DIFF_BITS-1] ? (~diff + DIFF_BITS'(1)) : diff;
    assign sq       = abs_diff * abs_diff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.rd_en;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        idx1_reg <= cmd.idx;
        idx2_reg <= idx1_reg;
        sq2_reg  <= sq;
    end

    // One read port on the accumulators, shared by the add and the scan.
    assign acc_rd_idx = cmd.scan_en ? cmd.idx : idx2_reg;
    assign acc_rd     = acc_reg[acc_rd_idx];
    assign acc_sum    = {1'b0, acc_rd} + (DIST_BITS + 1)'(sq2_reg);
    assign acc_new    = (acc_sum >= {1'b0, DIST_SAT}) ? DIST_SAT : acc_sum[DIST_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.emit) begin
            for (int i = 0; i < MAX_CENTERS; i++) begin
                acc_reg[i] <= '0;
            end
        end else if (v2_reg) begin
            acc_reg[idx2_reg] <= acc_new;
        end
    end

    // Running minimum; strict compare keeps the lowest index on a tie.
    always_ff @(posedge aclk) begin
        if (cmd.scan_en) begin
            if (cmd.scan_first || (acc_rd < best_d_reg)) begin
                best_d_reg  <= acc_rd;
                best_id_reg <= cmd.idx;
            end
        end
    end

    assign count_new = (count_reg[best_id_reg] == COUNT_SAT)
                     ? COUNT_SAT : count_reg[best_id_reg] + COUNT_BITS'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_CENTERS; i++) begin
                count_reg[i] <= '0;
            end
        end else if (cmd.emit) begin
            count_reg[best_id_reg] <= count_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_id_reg    <= best_id_reg;
            m_dist_reg  <= best_d_reg;
            m_count_reg <= count_new;
        end
    end

    assign status.out_free = !m_valid_reg || m_ready;
    assign m_valid         = m_valid_reg;
    assign m_cluster_id    = m_id_reg;
    assign m_distance_sq   = m_dist_reg;
    assign m_member_count  = m_count_reg;

`ifndef ASSERT_OFF
    a_valid_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(cmd.emit))
        else $error("result valid raised without a result command");

    a_emit_clears_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> m_valid_reg && (acc_reg[0] == '0) && !v2_reg)
        else $error("accumulators not cleared or pipeline busy after a result");
`endif

endmodule

>>> hw/rtl/nearest_centroid_assign.sv
// ============================================================================
// nearest_centroid_assign
// Nearest-centroid vector quantizer: loads centroid elements into a table,
// accumulates squared distances of a streamed point to every centroid in
// use and reports the nearest one with its distance and member count.
// ============================================================================
//
//   Channel   Handshake            Payload
//   -------   ------------------   ---------------------------------------------
//   input     s_valid / s_ready    s_req_type, s_center_index, s_dim_index,
//                                  s_value, s_last
//   result    m_valid / m_ready    m_cluster_id, m_distance_sq, m_member_count
//   config    cfg_wr_en            cfg_wr_data (centroids in use)
//
// A load transaction is written to the centroid store and the block is ready
// again at once. A point transaction sweeps the centroids in use through the
// centroid store's single read port, one centroid per cycle, and then drains
// the pipeline; one marked last also runs the minimum scan, which visits one
// accumulator per cycle, and then waits for the result register to empty.
// No new transaction is taken until the point is done.
// Reset is synchronous and active low; it clears the accumulators and member
// counts and sets the centroid count to 16. The centroid store is not
// cleared, so every element must be loaded before a point uses it.
// A stalled result stays in its register while the next point is taken in.
//
module nearest_centroid_assign (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    // Configuration: number of centroids compared for each point.
    input  logic                                  cfg_wr_en,
    input  logic [nca_pkg::NUM_BITS-1:0]          cfg_wr_data,

    // Input transactions.
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_req_type,
    input  logic [nca_pkg::CENTER_BITS-1:0]       s_center_index,
    input  logic [nca_pkg::DIM_BITS-1:0]          s_dim_index,
    input  logic signed [nca_pkg::VALUE_BITS-1:0] s_value,
    input  logic                                  s_last,

    // Result transactions.
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [nca_pkg::CENTER_BITS-1:0]       m_cluster_id,
    output logic [nca_pkg::DIST_BITS-1:0]         m_distance_sq,
    output logic [nca_pkg::COUNT_BITS-1:0]        m_member_count
);
    import nca_pkg::*;

    // Commands from the sequencer and status back from the datapath.
    ctrl_cmd_t  cmd;
    dp_status_t status;

    // The sequencer owns the handshake on the input side and the loop
    // counters; it walks the centroids once for the distance sweep and,
    // on the last element of a point, once more for the minimum search.
    nca_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_last      (s_last),
        .status      (status),
        .cmd         (cmd)
    );

    // The datapath holds the centroid store, the squared-difference pipe,
    // the accumulators, member counters and the result register.
    nca_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_center_index (s_center_index),
        .s_dim_index    (s_dim_index),
        .s_value        (s_value),
        .cmd            (cmd),
        .status         (status),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_cluster_id   (m_cluster_id),
        .m_distance_sq  (m_distance_sq),
        .m_member_count (m_member_count)
    );

endmodule
